// File: rtl/core/sil_pkg.sv
// sil_pkg: shared constants for the sorted insertion list
// action codes, data width and the default list capacity
// no dependencies
package sil_pkg;

   localparam int DATA_W = 32;
   localparam int ACT_W = 2;
   localparam int CAPACITY_DEFAULT = 64;

   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DUMP = 2'd1;
   localparam logic [ACT_W-1:0] ACT_REPORT = 2'd2;

endpackage

// File: rtl/core/sorted_insert_list_min_max_top.sv
// sorted_insert_list_min_max_top: bounded ascending list of signed words in one memory
// insert by top-down shift scan, dump in order, report largest and smallest
// depends on sil_pkg
//
// channel   ports                                  handshake
// request   req_action, req_value                  start high while busy low
// response  rsp_element, rsp_largest, rsp_smallest  rsp_valid strobe, one cycle, no stall
//           rsp_list_empty, rsp_rejected, rsp_last
//
// the list sits in one memory with a registered read port, one word read per cycle.
// insert: a full list rejects it and an empty list stores it at address 0; otherwise the
// scan runs from the top down, moving every stored value not smaller than the new one up a place.
// dump: one response per stored value in order (one empty response when empty); report: one response.
// reset clears state, count and rsp_valid; memory is never cleared, no entry past the count is read.
// results cannot be held off, so busy depends only on the operation in progress.
module sorted_insert_list_min_max_top #(
   parameter int CAPACITY = sil_pkg::CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [sil_pkg::ACT_W-1:0]         req_action,
   input  logic signed [sil_pkg::DATA_W-1:0] req_value,
   output logic                              rsp_valid,
   output logic signed [sil_pkg::DATA_W-1:0] rsp_element,
   output logic signed [sil_pkg::DATA_W-1:0] rsp_largest,
   output logic signed [sil_pkg::DATA_W-1:0] rsp_smallest,
   output logic                              rsp_list_empty,
   output logic                              rsp_rejected,
   output logic                              rsp_last
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int DW = sil_pkg::DATA_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_SCAN,
      ST_INS_PUT,
      ST_DUMP,
      ST_REP_HI,
      ST_REP_LO
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic signed [DW-1:0] value_ff, value_in;

   logic                 valid_ff, valid_in;
   logic signed [DW-1:0] element_ff, element_in;
   logic signed [DW-1:0] largest_ff, largest_in;
   logic signed [DW-1:0] smallest_ff, smallest_in;
   logic                 empty_ff, empty_in;
   logic                 rejected_ff, rejected_in;
   logic                 last_ff, last_in;

   // list memory
   logic signed [DW-1:0] mem [CAPACITY];
   logic signed [DW-1:0] rd_data_ff;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic signed [DW-1:0] wr_data;

   logic                 accept;
   logic                 is_full;
   logic                 is_empty;
   logic [AW-1:0]        top_addr;

   assign accept   = start && (state_ff == ST_IDLE);
   assign is_full  = (count_ff == CW'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign top_addr = AW'(count_ff - CW'(1));
   assign busy     = (state_ff != ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      value_in    = value_ff;
      valid_in    = 1'b0;
      element_in  = '0;
      largest_in  = '0;
      smallest_in = '0;
      empty_in    = 1'b0;
      rejected_in = 1'b0;
      last_in     = 1'b1;
      rd_en       = 1'b0;
      rd_addr     = '0;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = value_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               value_in = req_value;
               case (req_action)
                  sil_pkg::ACT_INSERT: begin
                     if (is_full) begin
                        valid_in    = 1'b1;
                        rejected_in = 1'b1;
                     end else if (is_empty) begin
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        wr_data  = req_value;
                        count_in = count_ff + CW'(1);
                        valid_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = top_addr;
                        idx_in   = top_addr;
                        state_in = ST_INS_SCAN;
                     end
                  end
                  sil_pkg::ACT_DUMP: begin
                     if (is_empty) begin
                        valid_in = 1'b1;
                        empty_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_in   = '0;
                        state_in = ST_DUMP;
                     end
                  end
                  sil_pkg::ACT_REPORT: begin
                     if (is_empty) begin
                        valid_in = 1'b1;
                        empty_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = top_addr;
                        state_in = ST_REP_HI;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_INS_SCAN: begin
            if (rd_data_ff < value_ff) begin
               // found the slot just above this entry
               wr_en    = 1'b1;
               wr_addr  = idx_ff + AW'(1);
               wr_data  = value_ff;
               count_in = count_ff + CW'(1);
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               // not smaller: move it up one place and keep scanning down
               wr_en   = 1'b1;
               wr_addr = idx_ff + AW'(1);
               wr_data = rd_data_ff;
               if (idx_ff == '0) begin
                  state_in = ST_INS_PUT;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff - AW'(1);
                  idx_in  = idx_ff - AW'(1);
               end
            end
         end
         ST_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = value_ff;
            count_in = count_ff + CW'(1);
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DUMP: begin
            valid_in   = 1'b1;
            element_in = rd_data_ff;
            if ((CW'(idx_ff) + CW'(1)) == count_ff) begin
               state_in = ST_IDLE;
            end else begin
               last_in = 1'b0;
               rd_en   = 1'b1;
               rd_addr = idx_ff + AW'(1);
               idx_in  = idx_ff + AW'(1);
            end
         end
         ST_REP_HI: begin
            value_in = rd_data_ff;
            rd_en    = 1'b1;
            rd_addr  = '0;
            state_in = ST_REP_LO;
         end
         ST_REP_LO: begin
            valid_in    = 1'b1;
            largest_in  = value_ff;
            smallest_in = rd_data_ff;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      idx_ff      <= idx_in;
      value_ff    <= value_in;
      element_ff  <= element_in;
      largest_ff  <= largest_in;
      smallest_ff <= smallest_in;
      empty_ff    <= empty_in;
      rejected_ff <= rejected_in;
      last_ff     <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_element    = element_ff;
   assign rsp_largest    = largest_ff;
   assign rsp_smallest   = smallest_ff;
   assign rsp_list_empty = empty_ff;
   assign rsp_rejected   = rejected_ff;
   assign rsp_last       = last_ff;

endmodule

// File: bench/sorted_insert_list_min_max_checker.sv
// sorted_insert_list_min_max_checker: watches the request and response channels of the list
// keeps its own copy of the sorted list, predicts every response and compares field by field
// depends on sil_pkg
module sorted_insert_list_min_max_checker #(
   parameter int CAPACITY = sil_pkg::CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [sil_pkg::ACT_W-1:0]         req_action,
   input  logic signed [sil_pkg::DATA_W-1:0] req_value,
   input  logic                              rsp_valid,
   input  logic signed [sil_pkg::DATA_W-1:0] rsp_element,
   input  logic signed [sil_pkg::DATA_W-1:0] rsp_largest,
   input  logic signed [sil_pkg::DATA_W-1:0] rsp_smallest,
   input  logic                              rsp_list_empty,
   input  logic                              rsp_rejected,
   input  logic                              rsp_last,
   output int                                fail_count,
   output int                                pending,
   output int                                results_checked,
   output int                                full_rejects
);

   typedef struct packed {
      logic signed [sil_pkg::DATA_W-1:0] element;
      logic signed [sil_pkg::DATA_W-1:0] largest;
      logic signed [sil_pkg::DATA_W-1:0] smallest;
      logic                              list_empty;
      logic                              rejected;
      logic                              last;
   } list_rsp_type;

   logic signed [sil_pkg::DATA_W-1:0] model_list [CAPACITY];
   int                                model_count = 0;
   list_rsp_type                      expected_rsp_q[$];
   int                                errors = 0;
   int                                queued = 0;
   int                                checked = 0;
   int                                rejects = 0;

   assign fail_count      = errors;
   assign pending         = queued;
   assign results_checked = checked;
   assign full_rejects    = rejects;

   // work out the responses of one accepted item and queue them
   task automatic predict_list_op(input logic [sil_pkg::ACT_W-1:0] action,
                                  input logic signed [sil_pkg::DATA_W-1:0] value);
      int           slot;
      list_rsp_type r;
      r = '0;
      case (action)
         sil_pkg::ACT_INSERT: begin
            r.last = 1'b1;
            if (model_count >= CAPACITY) begin
               r.rejected = 1'b1;
            end else begin
               // new value lands ahead of any equal ones
               slot = 0;
               while (slot < model_count && model_list[slot] < value) slot++;
               for (int j = model_count; j > slot; j--) model_list[j] = model_list[j-1];
               model_list[slot] = value;
               model_count++;
            end
            expected_rsp_q.push_back(r);
         end
         sil_pkg::ACT_DUMP: begin
            if (model_count == 0) begin
               r.list_empty = 1'b1;
               r.last       = 1'b1;
               expected_rsp_q.push_back(r);
            end else begin
               for (int j = 0; j < model_count; j++) begin
                  r.element = model_list[j];
                  r.last    = (j == model_count - 1);
                  expected_rsp_q.push_back(r);
               end
            end
         end
         sil_pkg::ACT_REPORT: begin
            r.last = 1'b1;
            if (model_count == 0) begin
               r.list_empty = 1'b1;
            end else begin
               r.largest  = model_list[model_count-1];
               r.smallest = model_list[0];
            end
            expected_rsp_q.push_back(r);
         end
         default: begin
            // unused code: no response
         end
      endcase
   endtask

   always @(posedge clock) begin
      list_rsp_type want;
      if (reset) begin
         model_count = 0;
         expected_rsp_q.delete();
      end else begin
         // predict first so a same-cycle response still finds its entry
         if (start === 1'b1 && busy === 1'b0) predict_list_op(req_action, req_value);
         if (rsp_valid === 1'b1) begin
            checked++;
            if (expected_rsp_q.size() == 0) begin
               $error("response with nothing outstanding: element %0d", rsp_element);
               errors++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (want.rejected) rejects++;
               if (rsp_element !== want.element) begin
                  $error("element: expected %0d, got %0d", want.element, rsp_element);
                  errors++;
               end
               if (rsp_largest !== want.largest) begin
                  $error("largest: expected %0d, got %0d", want.largest, rsp_largest);
                  errors++;
               end
               if (rsp_smallest !== want.smallest) begin
                  $error("smallest: expected %0d, got %0d", want.smallest, rsp_smallest);
                  errors++;
               end
               if (rsp_list_empty !== want.list_empty) begin
                  $error("list_empty: expected %0b, got %0b", want.list_empty, rsp_list_empty);
                  errors++;
               end
               if (rsp_rejected !== want.rejected) begin
                  $error("rejected: expected %0b, got %0b", want.rejected, rsp_rejected);
                  errors++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  errors++;
               end
            end
         end
      end
      queued = expected_rsp_q.size();
   end

endmodule

// File: bench/tb_sorted_insert_list_min_max_top.sv
// tb_sorted_insert_list_min_max_top: stimulus and verdict for the sorted insertion list
// drives directed then random items in bursts; checking lives in the checker module
// depends on sil_pkg, sorted_insert_list_min_max_top, sorted_insert_list_min_max_checker
module tb_sorted_insert_list_min_max_top;

   localparam int LIST_CAP     = sil_pkg::CAPACITY_DEFAULT;
   localparam int RANDOM_ITEMS = 400;
   localparam int CYCLE_LIMIT  = 400000;
   localparam logic [sil_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
   localparam logic signed [sil_pkg::DATA_W-1:0] INT_MIN = 32'sh8000_0000;
   localparam logic signed [sil_pkg::DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [sil_pkg::ACT_W-1:0]         req_action;
   logic signed [sil_pkg::DATA_W-1:0] req_value;
   logic                              rsp_valid;
   logic signed [sil_pkg::DATA_W-1:0] rsp_element;
   logic signed [sil_pkg::DATA_W-1:0] rsp_largest;
   logic signed [sil_pkg::DATA_W-1:0] rsp_smallest;
   logic                              rsp_list_empty;
   logic                              rsp_rejected;
   logic                              rsp_last;

   int fail_count;
   int pending;
   int results_checked;
   int full_rejects;

   int unsigned                       cycle_count = 0;
   int                                action_counts[4] = '{0, 0, 0, 0};
   logic signed [sil_pkg::DATA_W-1:0] inserted_values[$];

   sorted_insert_list_min_max_top #(.CAPACITY(LIST_CAP)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_element(rsp_element), .rsp_largest(rsp_largest),
      .rsp_smallest(rsp_smallest), .rsp_list_empty(rsp_list_empty),
      .rsp_rejected(rsp_rejected), .rsp_last(rsp_last)
   );

   sorted_insert_list_min_max_checker #(.CAPACITY(LIST_CAP)) list_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_element(rsp_element), .rsp_largest(rsp_largest),
      .rsp_smallest(rsp_smallest), .rsp_list_empty(rsp_list_empty),
      .rsp_rejected(rsp_rejected), .rsp_last(rsp_last),
      .fail_count(fail_count), .pending(pending),
      .results_checked(results_checked), .full_rejects(full_rejects)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // hold one item on the request port until the block takes it
   task automatic send_item(input logic [sil_pkg::ACT_W-1:0] action,
                            input logic signed [sil_pkg::DATA_W-1:0] value);
      @(negedge clock);
      start      = 1'b1;
      req_action = action;
      req_value  = value;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      action_counts[action]++;
      if (action == sil_pkg::ACT_INSERT) inserted_values.push_back(value);
   endtask

   // gap cycles carry junk on the request fields
   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start      = 1'b0;
         req_action = sil_pkg::ACT_W'($urandom);
         req_value  = $urandom;
      end
   endtask

   task automatic drain_responses();
      @(negedge clock);
      start = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   function automatic logic signed [sil_pkg::DATA_W-1:0] pick_value();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 45) return $urandom;
      if (sel < 65) return sil_pkg::DATA_W'(int'($urandom_range(0, 6)) - 3);
      if (sel < 80) begin
         case ($urandom_range(0, 3))
            0: return INT_MIN;
            1: return INT_MAX;
            2: return INT_MIN + 1;
            default: return INT_MAX - 1;
         endcase
      end
      // repeat an earlier value to get equal keys
      if (inserted_values.size() > 0)
         return inserted_values[$urandom_range(0, inserted_values.size() - 1)];
      return $urandom;
   endfunction

   function automatic logic [sil_pkg::ACT_W-1:0] pick_action();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 35) return sil_pkg::ACT_INSERT;
      if (sel < 55) return sil_pkg::ACT_DUMP;
      if (sel < 95) return sil_pkg::ACT_REPORT;
      return ACT_UNUSED;
   endfunction

   initial begin
      int                        counted;
      int                        burst_left;
      bit                        mid_drained;
      logic [sil_pkg::ACT_W-1:0] act;
      start      = 1'b0;
      req_action = sil_pkg::ACT_INSERT;
      req_value  = '0;
      reset      = 1'b1;
      counted     = 0;
      burst_left  = 0;
      mid_drained = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty list cases, unused code, then extremes and equal keys
      send_item(sil_pkg::ACT_REPORT, '0);
      send_item(sil_pkg::ACT_DUMP, '0);
      send_item(ACT_UNUSED, INT_MAX);
      send_item(sil_pkg::ACT_INSERT, 0);
      send_item(sil_pkg::ACT_REPORT, '0);
      send_item(sil_pkg::ACT_INSERT, INT_MAX);
      send_item(sil_pkg::ACT_INSERT, INT_MIN);
      send_item(sil_pkg::ACT_INSERT, -1);
      send_item(sil_pkg::ACT_INSERT, 0);
      send_item(sil_pkg::ACT_INSERT, INT_MAX);
      send_item(sil_pkg::ACT_INSERT, INT_MIN);
      send_item(sil_pkg::ACT_INSERT, 1);
      send_item(sil_pkg::ACT_DUMP, -1);
      send_item(sil_pkg::ACT_REPORT, -1);
      send_item(sil_pkg::ACT_INSERT, 32'sh5555_5555);
      send_item(sil_pkg::ACT_INSERT, 32'shaaaa_aaaa);
      send_item(sil_pkg::ACT_DUMP, '0);
      send_item(sil_pkg::ACT_REPORT, '0);
      drain_responses();

      while (counted < RANDOM_ITEMS) begin
         if (burst_left == 0) begin
            idle_cycles(($urandom_range(0, 3) == 0) ? $urandom_range(4, 20)
                                                    : $urandom_range(0, 3));
            burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
         end
         act = pick_action();
         send_item(act, pick_value());
         burst_left--;
         if (act != ACT_UNUSED) counted++;
         if (!mid_drained && counted >= RANDOM_ITEMS / 2) begin
            mid_drained = 1'b1;
            drain_responses();
         end
      end

      drain_responses();
      // room for a stray response from a late item
      repeat (LIST_CAP + 16) @(posedge clock);

      $display("accepted %0d inserts, %0d dumps, %0d reports and %0d unused-code items",
               action_counts[sil_pkg::ACT_INSERT], action_counts[sil_pkg::ACT_DUMP],
               action_counts[sil_pkg::ACT_REPORT], action_counts[ACT_UNUSED]);
      $display("checked %0d responses, %0d of them inserts turned away by a full list",
               results_checked, full_rejects);
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: sorted_insert_list_min_max_top.f
rtl/core/sil_pkg.sv
rtl/core/sorted_insert_list_min_max_top.sv
bench/sorted_insert_list_min_max_checker.sv
bench/tb_sorted_insert_list_min_max_top.sv
